### design/signed_gcd_lcm_unit_macros.svh
// assertion shorthands shared by the unit's modules
`ifndef SIGNED_GCD_LCM_UNIT_MACROS_SVH
`define SIGNED_GCD_LCM_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SGLU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sglu assertion failed");

// next-cycle implication, checked out of reset
`define SGLU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sglu assertion failed");

`endif

### design/sglu_pkg.sv
package sglu_pkg;

  localparam int OPERAND_WIDTH_DEF = 32;
  localparam int FIELD_WIDTH       = 32;
  localparam int VALUE_WIDTH       = 63;

  localparam logic ACT_GCD = 1'b0;
  localparam logic ACT_LCM = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_INVALID  = 2'd2
  } status_t;

  typedef struct packed {
    logic                          action;
    logic signed [FIELD_WIDTH-1:0] operand_a;
    logic signed [FIELD_WIDTH-1:0] operand_b;
  } req_t;

  typedef struct packed {
    status_t                status;
    logic [VALUE_WIDTH-1:0] value;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_DIV,
    S_MUL,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic mul;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic gcd_done;
    logic need_div;
    logic div_last;
  } dp_stat_t;

endpackage

### design/sglu_datapath.sv
`include "signed_gcd_lcm_unit_macros.svh"

module sglu_datapath #(
  parameter int W = sglu_pkg::OPERAND_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sglu_pkg::req_t     in_data,
  input  sglu_pkg::ctrl_cmd_t cmd,
  output sglu_pkg::dp_stat_t stat,
  output logic               out_valid,
  output sglu_pkg::res_t     out_data
);

  localparam int KW = $clog2(W);
  localparam int PW = 2 * W;

  logic            act_r;
  logic [W-1:0]    ma_r, mb_r;
  logic [W-1:0]    x_r, x_nxt;
  logic [W-1:0]    y_r, y_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  logic [W-1:0]    q_r, q_nxt;
  logic [W:0]      rem_r, rem_nxt;
  logic [KW-1:0]   cnt_r, cnt_nxt;
  logic [PW-1:0]   prod_r;
  logic            out_valid_r;
  sglu_pkg::res_t  out_data_r, out_data_nxt;

  logic [W-1:0]    raw_a, raw_b, mag_a, mag_b;
  logic [W-1:0]    g_w;
  logic [W:0]      rem_sh;
  logic [PW-1:0]   prod_w;
  logic            zero_op;

  assign raw_a = in_data.operand_a[W-1:0];
  assign raw_b = in_data.operand_b[W-1:0];
  // most negative value maps to 2^(W-1), still fits W unsigned bits
  assign mag_a = raw_a[W-1] ? W'(~raw_a + W'(1)) : raw_a;
  assign mag_b = raw_b[W-1] ? W'(~raw_b + W'(1)) : raw_b;

  // once one of x, y is zero the other holds the gcd without the shared 2^k
  assign g_w     = (x_r | y_r) << k_r;
  assign zero_op = (ma_r == '0) || (mb_r == '0);

  assign stat.gcd_done = (x_r == '0) || (y_r == '0);
  assign stat.need_div = (act_r == sglu_pkg::ACT_LCM) && !zero_op && !g_w[W-1];
  assign stat.div_last = (cnt_r == '0);

  // binary gcd, one step a cycle
  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    k_nxt = k_r;
    if (cmd.load) begin
      x_nxt = mag_a;
      y_nxt = mag_b;
      k_nxt = '0;
    end else if (cmd.gcd_step) begin
      case ({x_r[0], y_r[0]})
        2'b00: begin
          x_nxt = x_r >> 1;
          y_nxt = y_r >> 1;
          k_nxt = k_r + KW'(1);
        end
        2'b01: x_nxt = x_r >> 1;
        2'b10: y_nxt = y_r >> 1;
        default: begin
          // difference of two odd values is even
          if (x_r >= y_r) begin
            x_nxt = (x_r - y_r) >> 1;
          end else begin
            y_nxt = (y_r - x_r) >> 1;
          end
        end
      endcase
    end
  end

  // restoring divider for |a| / gcd, one quotient bit a cycle
  assign rem_sh = {rem_r[W-1:0], q_r[W-1]};

  always_comb begin
    q_nxt   = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (cmd.div_init) begin
      q_nxt   = ma_r;
      rem_nxt = '0;
      cnt_nxt = KW'(W - 1);
    end else if (cmd.div_step) begin
      cnt_nxt = cnt_r - KW'(1);
      if (rem_sh >= {1'b0, g_w}) begin
        rem_nxt = rem_sh - {1'b0, g_w};
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
    end
  end

  // product stays below 2^(2W-2), so at W = 32 it fits the 63-bit value with no range check
  assign prod_w = PW'(q_r) * PW'(mb_r);

  always_comb begin
    out_data_nxt.status = sglu_pkg::ST_OK;
    out_data_nxt.value  = '0;
    if (act_r == sglu_pkg::ACT_GCD) begin
      if (g_w[W-1]) begin
        out_data_nxt.status = sglu_pkg::ST_OVERFLOW;
      end else begin
        out_data_nxt.value = sglu_pkg::VALUE_WIDTH'(g_w);
      end
    end else if (zero_op) begin
      out_data_nxt.value = '0;
    end else if (g_w[W-1]) begin
      out_data_nxt.status = sglu_pkg::ST_INVALID;
    end else begin
      out_data_nxt.value = sglu_pkg::VALUE_WIDTH'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_data.action;
      ma_r  <= mag_a;
      mb_r  <= mag_b;
    end
    if (cmd.mul) begin
      prod_r <= prod_w;
    end
    if (cmd.emit) begin
      out_data_r <= out_data_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    k_r   <= k_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SGLU_ASSERT_IMPL(a_step_not_done, clk, rst_n, cmd.gcd_step, !stat.gcd_done)
  `SGLU_ASSERT_IMPL(a_div_by_valid_gcd, clk, rst_n, cmd.div_step, (g_w != '0) && !g_w[W-1])
  `SGLU_ASSERT_IMPL(a_error_zero, clk, rst_n,
      out_valid_r && (out_data_r.status != sglu_pkg::ST_OK), out_data_r.value == '0)

endmodule

### design/sglu_ctrl.sv
`include "signed_gcd_lcm_unit_macros.svh"

module sglu_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  sglu_pkg::dp_stat_t  stat,
  output logic                busy,
  output sglu_pkg::ctrl_cmd_t cmd
);

  sglu_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sglu_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sglu_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = sglu_pkg::S_GCD;
        end
      end
      sglu_pkg::S_GCD: begin
        if (stat.gcd_done) begin
          state_nxt = stat.need_div ? sglu_pkg::S_DIV : sglu_pkg::S_IDLE;
        end
      end
      sglu_pkg::S_DIV: begin
        if (stat.div_last) begin
          state_nxt = sglu_pkg::S_MUL;
        end
      end
      sglu_pkg::S_MUL: state_nxt = sglu_pkg::S_FIN;
      sglu_pkg::S_FIN: state_nxt = sglu_pkg::S_IDLE;
      default:         state_nxt = sglu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      sglu_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      sglu_pkg::S_GCD: begin
        cmd.gcd_step = !stat.gcd_done;
        cmd.div_init = stat.gcd_done && stat.need_div;
        cmd.emit     = stat.gcd_done && !stat.need_div;
      end
      sglu_pkg::S_DIV: cmd.div_step = 1'b1;
      sglu_pkg::S_MUL: cmd.mul = 1'b1;
      sglu_pkg::S_FIN: cmd.emit = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  `SGLU_ASSERT_NEXT(a_emit_to_idle, clk, rst_n, cmd.emit, state_r == sglu_pkg::S_IDLE)
  `SGLU_ASSERT_NEXT(a_div_to_mul, clk, rst_n,
      (state_r == sglu_pkg::S_DIV) && stat.div_last, state_r == sglu_pkg::S_MUL)
  `SGLU_ASSERT_IMPL(a_one_cmd, clk, rst_n, 1'b1,
      $onehot0({cmd.load, cmd.gcd_step, cmd.div_init, cmd.div_step, cmd.mul, cmd.emit}))

endmodule

### design/signed_gcd_lcm_unit.sv
// signed gcd / lcm unit
// a request is taken on a rising edge with start high and busy low; it carries
// the action (0 gcd, 1 lcm) and two signed operands, of which the low
// OPERAND_WIDTH bits count. busy stays high until the result is issued.
// the result appears on out_data for exactly one cycle with out_valid high;
// the receiver cannot stall it, so it must take it in that cycle.
// status: 0 ok, 1 overflow (gcd of 2^(W-1)), 2 invalid (lcm of two most
// negative values); value is 0 on any error.
// operation, W = OPERAND_WIDTH: the gcd is a binary gcd on the magnitudes,
// one shift or subtract-and-shift per cycle, its step count data dependent.
// lcm adds a restoring divide for |a|/gcd and a registered W x W multiply;
// an lcm with a zero operand or two most negative operands skips them. one
// request at a time: the next one can be taken in the cycle the result is
// shown.
// reset returns the controller to idle and drops any request in flight.
module signed_gcd_lcm_unit #(
  parameter int OPERAND_WIDTH = sglu_pkg::OPERAND_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  sglu_pkg::req_t  in_data,
  output logic            out_valid,
  output sglu_pkg::res_t  out_data
);

  sglu_pkg::ctrl_cmd_t cmd;
  sglu_pkg::dp_stat_t  stat;

  sglu_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  sglu_datapath #(
    .W (OPERAND_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
